@@ sv/salc_pkg.sv @@
// ----------------------------------------------------------------------------
// salc_pkg: shared types and constants for the set-associative LRU cache timing block.
// Holds the mode codes, the config register indexes, the field maxima and the
// default geometry parameters. Also holds the struct that crosses the front/back queue.
// ----------------------------------------------------------------------------
package salc_pkg;

   localparam int DEF_NUM_SETS    = 128;
   localparam int DEF_NUM_WAYS    = 4;
   localparam int DEF_BLOCK_BYTES = 64;

   localparam int ADDR_W  = 32;
   localparam int WB_W    = 10;
   localparam int CYC_W   = 19;
   localparam int BYTES_W = 16;
   localparam int CSR_W   = 10;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_FLUSH = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_WB_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WA_MODE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIT_CYC    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MISS_CYC   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WT_CYC     = 3'd4;

   localparam logic [CYC_W-1:0]   CYC_MAX   = '1;
   localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
   localparam logic [WB_W-1:0]    WB_MAX    = '1;

   // config as seen by the back end
   typedef struct packed {
      logic       wb_mode;
      logic       wa_mode;
      logic [7:0] hit_cyc;
      logic [9:0] miss_cyc;
      logic [7:0] wt_cyc;
   } cfg_type;

   // transaction handed from front to back
   typedef struct packed {
      mode_type          mode;
      logic [ADDR_W-1:0] address;
   } cmd_type;

   // result transaction
   typedef struct packed {
      logic               hit;
      logic [WB_W-1:0]    wb_cnt;
      logic [CYC_W-1:0]   cyc;
      logic [BYTES_W-1:0] bytes;
   } rsp_type;

endpackage

@@ sv/set_assoc_lru_cache_timing.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_timing: tag store and cost model of a set-assoc LRU cache
// Front end queues transactions, back end does lookup/update or flush and
// pushes one result transaction per request into the response queue.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------
//  request | req_mode, req_address                   | push / full
//  result  | rsp_hit, rsp_writeback_count,           | empty / pop
//          | rsp_cycles_charged, rsp_bytes_moved     |
//  config  | csr_wr_en, csr_index, csr_data          | write, no wait
//
//  Read/write: take + set RAM read, then resolve + row write, then result
//  push. Flush in write-back mode walks every set, one set per cycle; flush
//  in write-through and unused mode goes straight to the result push.
//  The request queue (2 deep) keeps accepting while the back end works;
//  the 2-deep result queue decouples pop from the engine, which waits in its
//  push cycle while that queue is full.
//  Reset is synchronous; the back end then writes a cleared row into every
//  set of the set RAM before it takes the first request.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_timing #(
   parameter int NUM_SETS    = salc_pkg::DEF_NUM_SETS,
   parameter int NUM_WAYS    = salc_pkg::DEF_NUM_WAYS,
   parameter int BLOCK_BYTES = salc_pkg::DEF_BLOCK_BYTES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [1:0]                     req_mode,
   input  logic [salc_pkg::ADDR_W-1:0]    req_address,
   output logic                           empty,
   input  logic                           pop,
   output logic                           rsp_hit,
   output logic [salc_pkg::WB_W-1:0]      rsp_writeback_count,
   output logic [salc_pkg::CYC_W-1:0]     rsp_cycles_charged,
   output logic [salc_pkg::BYTES_W-1:0]   rsp_bytes_moved,
   input  logic                           csr_wr_en,
   input  logic [salc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [salc_pkg::CSR_W-1:0]     csr_data
);
   import salc_pkg::*;

   cfg_type cfg_ff;
   cmd_type req_cmd, q_cmd;
   rsp_type b_rsp, q_rsp;
   logic    q_empty, q_take, r_full, r_push;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wb_mode  <= 1'b0;
         cfg_ff.wa_mode  <= 1'b1;
         cfg_ff.hit_cyc  <= 8'd1;
         cfg_ff.miss_cyc <= 10'd100;
         cfg_ff.wt_cyc   <= 8'd8;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WB_MODE:  cfg_ff.wb_mode  <= csr_data[0];
            CSR_WA_MODE:  cfg_ff.wa_mode  <= csr_data[0];
            CSR_HIT_CYC:  cfg_ff.hit_cyc  <= csr_data[7:0];
            CSR_MISS_CYC: cfg_ff.miss_cyc <= csr_data;
            CSR_WT_CYC:   cfg_ff.wt_cyc   <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign req_cmd.mode    = mode_type'(req_mode);
   assign req_cmd.address = req_address;

   // front: request queue
   salc_queue #(.WIDTH($bits(cmd_type))) u_req_q (
      .clock(clock), .reset(reset),
      .push(push), .push_data(req_cmd), .full(full),
      .pop(q_take), .pop_data(q_cmd), .empty(q_empty)
   );

   // back: lookup engine
   salc_back #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS),
               .BLOCK_BYTES(BLOCK_BYTES)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .cmd_valid(!q_empty), .cmd(q_cmd), .cmd_take(q_take),
      .rsp_full(r_full), .rsp_push(r_push), .rsp(b_rsp)
   );

   // result queue
   salc_queue #(.WIDTH($bits(rsp_type))) u_rsp_q (
      .clock(clock), .reset(reset),
      .push(r_push), .push_data(b_rsp), .full(r_full),
      .pop(pop), .pop_data(q_rsp), .empty(empty)
   );

   assign rsp_hit             = q_rsp.hit;
   assign rsp_writeback_count = q_rsp.wb_cnt;
   assign rsp_cycles_charged  = q_rsp.cyc;
   assign rsp_bytes_moved     = q_rsp.bytes;

   // a result transaction is only pushed when the result queue has room
   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      r_push |-> !r_full) else $error("result pushed into full queue");
   a_take_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_take |-> !q_empty) else $error("engine took from empty queue");
   a_no_take_push: assert property (@(posedge clock) disable iff (reset)
      q_take |-> !r_push) else $error("take and push in same cycle");
   a_hit_costs: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_hit) |-> rsp_writeback_count == '0)
      else $error("hit with writeback");
endmodule

@@ sv/salc_ram.sv @@
// ----------------------------------------------------------------------------
// salc_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ sv/salc_queue.sv @@
// ----------------------------------------------------------------------------
// salc_queue: small two-entry FIFO
// Used between front and back and as the result queue.
// ----------------------------------------------------------------------------
module salc_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   logic [WIDTH-1:0] data_ff [2];
   logic             rptr_ff, rptr_in, wptr_ff, wptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign pop_data = data_ff[rptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      rptr_in = rptr_ff ^ do_pop;
      wptr_in = wptr_ff ^ do_push;
      cnt_in  = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rptr_ff <= 1'b0;
         wptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         rptr_ff <= rptr_in;
         wptr_ff <= wptr_in;
         cnt_ff  <= cnt_in;
      end
      if (do_push) begin
         data_ff[wptr_ff] <= push_data;
      end
   end
endmodule

@@ sv/salc_back.sv @@
// ----------------------------------------------------------------------------
// salc_back: lookup / update engine
// Reads one set row from RAM, resolves hit and victim, writes the row back.
// Valid, dirty, LRU rank and tag of every way share one RAM row per set.
// A clearing pass after reset writes the reset row into every set.
// In write-back mode, flush walks every set, one row per cycle.
// ----------------------------------------------------------------------------
module salc_back #(
   parameter int NUM_SETS    = 128,
   parameter int NUM_WAYS    = 4,
   parameter int BLOCK_BYTES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  salc_pkg::cfg_type cfg,
   input  logic              cmd_valid,
   input  salc_pkg::cmd_type cmd,
   output logic              cmd_take,
   input  logic              rsp_full,
   output logic              rsp_push,
   output salc_pkg::rsp_type rsp
);
   import salc_pkg::*;

   localparam int OB     = $clog2(BLOCK_BYTES);
   localparam int IB     = $clog2(NUM_SETS);
   localparam int SET_W  = (IB > 0) ? IB : 1;
   localparam int TAG_W  = ADDR_W - OB - IB;
   localparam int RANK_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int WAY_W  = RANK_W;
   localparam int CNT_W  = $clog2(NUM_WAYS + 1);
   localparam logic [BYTES_W-1:0] BLK_BYTES = BYTES_W'(BLOCK_BYTES);

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [RANK_W-1:0] rank;
      logic              dirty;
      logic              valid;
   } way_type;

   localparam int ROW_W = NUM_WAYS * $bits(way_type);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_LOOK  = 5'b00100,
      ST_FLUSH = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   cmd_type           cmd_ff;
   logic [SET_W-1:0]  wset_ff, wset_in;
   logic [WB_W:0]     wb_ff, wb_in;
   logic [CYC_W:0]    cyc_ff, cyc_in;
   logic [BYTES_W:0]  bytes_ff, bytes_in;
   logic              hit_ff, hit_in;

   way_type [NUM_WAYS-1:0] row_rd, row_wr, row_init, row_look, row_flush;
   logic              ram_we;
   logic [SET_W-1:0]  ram_waddr, ram_raddr;
   logic [SET_W-1:0]  set_idx;
   logic [TAG_W-1:0]  tag;

   function automatic logic [SET_W-1:0] set_of(input logic [ADDR_W-1:0] a);
      if (IB > 0) set_of = SET_W'(a[OB +: SET_W]);
      else        set_of = '0;
   endfunction

   assign set_idx = set_of(cmd_ff.address);
   assign tag     = cmd_ff.address[ADDR_W-1 -: TAG_W];

   // read the set on take, the next set while flushing, else hold
   always_comb begin
      ram_raddr = set_idx;
      if (cmd_take) begin
         ram_raddr = (cmd.mode == MODE_FLUSH) ? '0 : set_of(cmd.address);
      end else if (state_ff == ST_FLUSH) begin
         ram_raddr = wset_ff + SET_W'(1);
      end
   end

   assign ram_we    = state_ff == ST_CLEAR || state_ff == ST_LOOK || state_ff == ST_FLUSH;
   assign ram_waddr = (state_ff == ST_LOOK) ? set_idx : wset_ff;

   always_comb begin
      case (state_ff)
         ST_CLEAR: row_wr = row_init;
         ST_LOOK:  row_wr = row_look;
         default:  row_wr = row_flush;
      endcase
   end

   salc_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_sets (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (row_wr),
      .rd_addr (ram_raddr),
      .rd_data (row_rd)
   );

   // reset row: all invalid, clean, rank = way number
   always_comb begin
      for (int w = 0; w < NUM_WAYS; w++) begin
         row_init[w].tag   = '0;
         row_init[w].rank  = RANK_W'(w);
         row_init[w].dirty = 1'b0;
         row_init[w].valid = 1'b0;
      end
   end

   // saturating adds
   function automatic logic [CYC_W:0] add_c(input logic [CYC_W:0] a,
                                           input logic [CYC_W-1:0] b);
      logic [CYC_W+1:0] s;
      s = {1'b0, a} + (CYC_W+2)'(b);
      add_c = (s > (CYC_W+2)'(CYC_MAX)) ? (CYC_W+1)'(CYC_MAX) : s[CYC_W:0];
   endfunction
   function automatic logic [BYTES_W:0] add_b(input logic [BYTES_W:0] a,
                                             input logic [BYTES_W-1:0] b);
      logic [BYTES_W+1:0] s;
      s = {1'b0, a} + (BYTES_W+2)'(b);
      add_b = (s > (BYTES_W+2)'(BYTES_MAX)) ? (BYTES_W+1)'(BYTES_MAX) : s[BYTES_W:0];
   endfunction

   // lookup resolution
   logic                is_wr, found, any_inv, do_fill, wb_hit;
   logic [WAY_W-1:0]    hway, iway, lway, vway, uway;
   logic [RANK_W-1:0]   urank;

   always_comb begin
      is_wr = cmd_ff.mode == MODE_WRITE;
      found = 1'b0; hway = '0;
      any_inv = 1'b0; iway = '0; lway = '0;
      for (int w = NUM_WAYS-1; w >= 0; w--) begin
         if (row_rd[w].valid && row_rd[w].tag == tag) begin
            found = 1'b1; hway = WAY_W'(w);
         end
         if (!row_rd[w].valid) begin
            any_inv = 1'b1; iway = WAY_W'(w);
         end
         if (row_rd[w].rank == '0) lway = WAY_W'(w);
      end
      vway    = any_inv ? iway : lway;
      wb_hit  = !found && !any_inv && cfg.wb_mode && row_rd[lway].dirty;
      do_fill = !found && !(is_wr && !cfg.wa_mode);
      uway    = found ? hway : vway;
      urank   = row_rd[uway].rank;
      row_look = row_rd;
      if (found || do_fill) begin
         for (int w = 0; w < NUM_WAYS; w++) begin
            if (WAY_W'(w) == uway) row_look[w].rank = RANK_W'(NUM_WAYS-1);
            else if (row_rd[w].rank > urank)
               row_look[w].rank = row_rd[w].rank - RANK_W'(1);
         end
      end
      // no-allocate write miss leaves the row as it was
      if (found) begin
         if (is_wr && cfg.wb_mode) row_look[hway].dirty = 1'b1;
      end else if (do_fill) begin
         row_look[vway].valid = 1'b1;
         row_look[vway].dirty = is_wr && cfg.wb_mode;
         row_look[vway].tag   = tag;
      end
   end

   // accounting
   logic [CYC_W:0]   c0, c1, c2, c3;
   logic [BYTES_W:0] b0, b1, b2, b3;
   always_comb begin
      c0 = add_c('0, CYC_W'(cfg.hit_cyc));
      b0 = '0;
      c1 = c0; b1 = b0; c2 = c0; b2 = b0;
      if (found) begin
         if (is_wr && !cfg.wb_mode) begin
            c1 = add_c(c0, CYC_W'(cfg.wt_cyc)); b1 = add_b(b0, BLK_BYTES);
         end
         c3 = c1; b3 = b1;
      end else begin
         c1 = add_c(c0, CYC_W'(cfg.miss_cyc)); b1 = add_b(b0, BLK_BYTES);
         c2 = c1; b2 = b1;
         if (wb_hit) begin
            c2 = add_c(c1, CYC_W'(cfg.miss_cyc)); b2 = add_b(b1, BLK_BYTES);
         end
         c3 = c2; b3 = b2;
         if (is_wr && !cfg.wa_mode) begin
            c3 = add_c(c2, CYC_W'(cfg.miss_cyc)); b3 = add_b(b2, BLK_BYTES);
         end else if (is_wr && !cfg.wb_mode) begin
            c3 = add_c(c2, CYC_W'(cfg.wt_cyc)); b3 = add_b(b2, BLK_BYTES);
         end
      end
   end

   assign cmd_take = state_ff == ST_IDLE && cmd_valid;
   assign rsp_push = state_ff == ST_DONE && !rsp_full;

   always_comb begin
      rsp.hit    = hit_ff;
      rsp.wb_cnt = wb_ff[WB_W-1:0];
      rsp.cyc    = cyc_ff[CYC_W-1:0];
      rsp.bytes  = bytes_ff[BYTES_W-1:0];
   end

   // flush: count dirty valid ways of the row, clean them
   logic [CNT_W-1:0]   fl_n;
   logic [CYC_W-1:0]   fl_cyc;
   logic [BYTES_W-1:0] fl_bytes;
   logic [WB_W:0]      wb_sum;
   always_comb begin
      row_flush = row_rd;
      fl_n      = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (row_rd[w].valid && row_rd[w].dirty) begin
            fl_n = fl_n + CNT_W'(1);
            row_flush[w].dirty = 1'b0;
         end
      end
      fl_cyc   = CYC_W'(fl_n) * CYC_W'(cfg.miss_cyc);
      fl_bytes = BYTES_W'(fl_n) * BLK_BYTES;
      wb_sum   = wb_ff + (WB_W+1)'(fl_n);
   end

   always_comb begin
      state_in = state_ff;
      wset_in  = wset_ff;
      wb_in = wb_ff; cyc_in = cyc_ff; bytes_in = bytes_ff; hit_in = hit_ff;
      case (state_ff)
         ST_CLEAR: begin
            wset_in = wset_ff + SET_W'(1);
            if (wset_ff == SET_W'(NUM_SETS-1)) begin
               wset_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               wb_in = '0; cyc_in = '0; bytes_in = '0; hit_in = 1'b0;
               wset_in = '0;
               case (cmd.mode)
                  MODE_READ, MODE_WRITE: state_in = ST_LOOK;
                  MODE_FLUSH: state_in = cfg.wb_mode ? ST_FLUSH : ST_DONE;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_LOOK: begin
            hit_in = found;
            wb_in  = (WB_W+1)'(wb_hit);
            cyc_in = c3; bytes_in = b3;
            state_in = ST_DONE;
         end
         ST_FLUSH: begin
            cyc_in   = add_c(cyc_ff, fl_cyc);
            bytes_in = add_b(bytes_ff, fl_bytes);
            wb_in    = (wb_sum > (WB_W+1)'(WB_MAX)) ? (WB_W+1)'(WB_MAX) : wb_sum;
            wset_in  = wset_ff + SET_W'(1);
            if (wset_ff == SET_W'(NUM_SETS-1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_full) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         wset_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wset_ff  <= wset_in;
      end
      if (cmd_take) cmd_ff <= cmd;
      wb_ff <= wb_in; cyc_ff <= cyc_in; bytes_ff <= bytes_in; hit_ff <= hit_in;
   end
endmodule
